/* rtl/assert_macros.svh */
// assertion helpers, clocked on aclk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define GCDP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("gcdp check failed");

`define GCDP_ASSERT_IMPLY(lbl, ante, cons) \
    `GCDP_ASSERT(lbl, (ante) |-> (cons))

`endif

/* rtl/gcdp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gcdp_pkg;

    localparam int IN_W    = 16;
    localparam int MUL_W   = 24;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int PAIR_W  = 2 * IN_W;
    localparam int TERM_W  = PAIR_W + 1;
    localparam int ACC_W   = 40;
    localparam int ACC_N   = 4;
    localparam int SEL_W   = $clog2(ACC_N);
    localparam int TOTAL_W = 56;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic             first_en;
        logic             acc_en;
        logic             sub;
        logic             sq_en;
        logic             clear_acc;
        logic             clear_total;
        logic [SEL_W-1:0] sel;
    } acc_ctl_t;

endpackage

`default_nettype wire

/* rtl/gcdp_mult.sv */
`timescale 1ns / 1ps
`default_nettype none

module gcdp_mult (
    input  wire                                 aclk,
    input  wire logic signed [gcdp_pkg::MUL_W-1:0]  a,
    input  wire logic signed [gcdp_pkg::MUL_W-1:0]  b,
    output logic signed [gcdp_pkg::PROD_W-1:0]      p
);
    import gcdp_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* rtl/gcdp_acc.sv */
`timescale 1ns / 1ps
`default_nettype none

module gcdp_acc (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire gcdp_pkg::acc_ctl_t                 ctl,
    input  wire logic signed [gcdp_pkg::PROD_W-1:0] prod,
    output logic signed [gcdp_pkg::MUL_W-1:0]       sq_operand,
    output logic [gcdp_pkg::TOTAL_W-1:0]            total,
    output logic                                    sat
);
    import gcdp_pkg::*;

    logic signed [ACC_W-1:0]  acc_reg [ACC_N];
    logic signed [PAIR_W-1:0] first_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic                     sat_reg;

    logic signed [ACC_W-1:0]  acc_cur;
    logic signed [PAIR_W-1:0] prod_lo;
    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W-1:0]  acc_next;
    logic [TOTAL_W:0]         tot_sum;
    logic                     tot_hit;

    always_comb begin
        acc_cur = acc_reg[ctl.sel];
        prod_lo = prod[PAIR_W-1:0];
        if (ctl.sub) begin
            term = {first_reg[PAIR_W-1], first_reg} - {prod_lo[PAIR_W-1], prod_lo};
        end else begin
            term = {first_reg[PAIR_W-1], first_reg} + {prod_lo[PAIR_W-1], prod_lo};
        end
        acc_sum = {acc_cur[ACC_W-1], acc_cur}
                + {{(ACC_W + 1 - TERM_W){term[TERM_W-1]}}, term};
        // clamp to the 40 bit signed range
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                      : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
        tot_sum = {1'b0, total_reg} + (TOTAL_W + 1)'($unsigned(prod));
        tot_hit = tot_sum >= {1'b0, TOTAL_MAX};
    end

    // floor of acc / 2^16
    assign sq_operand = acc_cur[ACC_W-1 -: MUL_W];
    assign total      = total_reg;
    assign sat        = sat_reg;

    always_ff @(posedge aclk) begin
        if (ctl.first_en) begin
            first_reg <= prod_lo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ACC_N; i++) begin
                acc_reg[i] <= '0;
            end
            total_reg <= '0;
            sat_reg   <= 1'b0;
        end else begin
            if (ctl.clear_acc) begin
                for (int i = 0; i < ACC_N; i++) begin
                    acc_reg[i] <= '0;
                end
            end else if (ctl.acc_en) begin
                acc_reg[ctl.sel] <= acc_next;
            end
            if (ctl.clear_total) begin
                total_reg <= '0;
                sat_reg   <= 1'b0;
            end else if (ctl.sq_en) begin
                if (tot_hit) begin
                    total_reg <= TOTAL_MAX;
                    sat_reg   <= 1'b1;
                end else begin
                    total_reg <= tot_sum[TOTAL_W-1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/grouped_complex_dot_power_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Grouped complex dot power. Each request carries a complex denominator d and two
// complex factors theta and phi (all signed Q1.15); the unit accumulates d*theta and
// d*phi with 40 bit saturating accumulators. On a group end (s_tuser, or s_tlast) the
// four accumulator parts are cut to 24 bits (floor by 2^16), squared and added into a
// 56 bit saturating cell total, and the accumulators clear. On a cell end (s_tlast)
// the total and its saturation flag go out on the m_ side and the total clears.
// All products and squares share one registered 24x24 multiplier. A request runs through
// its products, then the squares when it closes a group and the output load when it
// closes a cell, and that load waits while the previous result is held on m_tready.
// s_tready is low while a request is in work.
module grouped_complex_dot_power_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // denom_re, denom_im, theta_re, theta_im, phi_re, phi_im
    input  wire [95:0]  s_tdata,
    // group_end
    input  wire         s_tuser,
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    // intensity
    output logic [55:0] m_tdata,
    // saturated
    output logic        m_tuser
);
    import gcdp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_SQR  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic signed [IN_W-1:0]  dr_reg, di_reg, tr_reg, ti_reg, pr_reg, pi_reg;
    logic                    gend_reg, cend_reg;
    logic                    m_valid_reg;
    logic [TOTAL_W-1:0]      m_data_reg;
    logic                    m_sat_reg;

    acc_ctl_t                ctl;
    logic signed [IN_W-1:0]  op_a, op_b;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [MUL_W-1:0] sq_operand;
    logic [TOTAL_W-1:0]      total;
    logic                    sat;
    logic                    accept;
    logic                    load_out;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    always_comb begin
        unique case (cnt_reg[2:0])
            3'd0: begin op_a = dr_reg; op_b = tr_reg; end
            3'd1: begin op_a = di_reg; op_b = ti_reg; end
            3'd2: begin op_a = dr_reg; op_b = ti_reg; end
            3'd3: begin op_a = di_reg; op_b = tr_reg; end
            3'd4: begin op_a = dr_reg; op_b = pr_reg; end
            3'd5: begin op_a = di_reg; op_b = pi_reg; end
            3'd6: begin op_a = dr_reg; op_b = pi_reg; end
            default: begin op_a = di_reg; op_b = pr_reg; end
        endcase
        if (state_reg == ST_SQR) begin
            mul_a = sq_operand;
            mul_b = sq_operand;
        end else begin
            mul_a = {{(MUL_W-IN_W){op_a[IN_W-1]}}, op_a};
            mul_b = {{(MUL_W-IN_W){op_b[IN_W-1]}}, op_b};
        end
    end

    always_comb begin
        ctl            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MUL;
                    cnt_next   = '0;
                end
            end
            ST_MUL: begin
                // products land a count late through the multiplier register: odd count holds the first of a pair
                ctl.first_en = cnt_reg[0];
                ctl.acc_en   = !cnt_reg[0] && (cnt_reg != '0);
                ctl.sel      = SEL_W'(cnt_reg[3:1] - 3'd1);
                ctl.sub      = !ctl.sel[0];
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8) begin
                    cnt_next   = '0;
                    state_next = (gend_reg || cend_reg) ? ST_SQR : ST_IDLE;
                end
            end
            ST_SQR: begin
                ctl.sel   = cnt_reg[SEL_W-1:0];
                ctl.sq_en = (cnt_reg != '0);
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'd4) begin
                    ctl.clear_acc = 1'b1;
                    cnt_next      = '0;
                    state_next    = cend_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (load_out) begin
                    ctl.clear_total = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dr_reg   <= s_tdata[15:0];
            di_reg   <= s_tdata[31:16];
            tr_reg   <= s_tdata[47:32];
            ti_reg   <= s_tdata[63:48];
            pr_reg   <= s_tdata[79:64];
            pi_reg   <= s_tdata[95:80];
            gend_reg <= s_tuser;
            cend_reg <= s_tlast;
        end
        if (load_out) begin
            m_data_reg <= total;
            m_sat_reg  <= sat;
        end
    end

    gcdp_mult u_mult (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    gcdp_acc u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .prod       (prod),
        .sq_operand (sq_operand),
        .total      (total),
        .sat        (sat)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

endmodule

`default_nettype wire

/* rtl/gcdp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gcdp_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [55:0] m_tdata,
    input wire        m_tuser
);

    // after a request the unit is still busy when the last of its eight products is accumulated
    `GCDP_ASSERT(busy_after_req, (s_tvalid && s_tready) |=> ##8 !s_tready)
    // a result only appears out of a busy cycle
    `GCDP_ASSERT_IMPLY(result_from_work, $rose(m_tvalid), $past(!s_tready))
    // saturation flag and all-ones total go together
    `GCDP_ASSERT_IMPLY(sat_matches_total, m_tvalid, m_tuser == (&m_tdata))
    `GCDP_ASSERT(out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

bind grouped_complex_dot_power_unit gcdp_checker u_checker (.*);

`default_nettype wire
